### rtl/infix_to_postfix_converter_top_defines.svh
// Assertion macros shared by the infix to postfix converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/itp_pkg.sv
// Package: payload types, operator codes, status codes and lookup functions.
package itp_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;

    // Operator stack codes
    localparam logic [2:0] CODE_NONE  = 3'd0;
    localparam logic [2:0] CODE_LPAR  = 3'd1;
    localparam logic [2:0] CODE_PLUS  = 3'd2;
    localparam logic [2:0] CODE_MINUS = 3'd3;
    localparam logic [2:0] CODE_MUL   = 3'd4;
    localparam logic [2:0] CODE_DIV   = 3'd5;
    localparam logic [2:0] CODE_POW   = 3'd6;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_UNMATCHED = 3'd2;
    localparam logic [2:0] ST_UNCLOSED  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    // Characters
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_MUL   = 8'd42;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DIV   = 8'd47;
    localparam logic [7:0] CH_POW   = 8'd94;
    localparam logic [7:0] CH_NUL   = 8'd0;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_expr;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       has_symbol;
        logic       out_last;
        logic [2:0] status;
    } t_out_item;

    // Decode result handed from the classifier to the sequencer
    typedef struct packed {
        logic       letter;
        logic       rparen;
        logic [2:0] code;
        logic       top_lpar;
        logic       top_pops;
    } t_class;

    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            CH_LPAR:  r = CODE_LPAR;
            CH_PLUS:  r = CODE_PLUS;
            CH_MINUS: r = CODE_MINUS;
            CH_MUL:   r = CODE_MUL;
            CH_DIV:   r = CODE_DIV;
            CH_POW:   r = CODE_POW;
            default:  r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] r;
        case (code)
            CODE_LPAR:  r = CH_LPAR;
            CODE_PLUS:  r = CH_PLUS;
            CODE_MINUS: r = CH_MINUS;
            CODE_MUL:   r = CH_MUL;
            CODE_DIV:   r = CH_DIV;
            CODE_POW:   r = CH_POW;
            default:    r = CH_NUL;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] code_prec(input logic [2:0] code);
        logic [1:0] r;
        case (code)
            CODE_PLUS, CODE_MINUS: r = 2'd1;
            CODE_MUL, CODE_DIV:    r = 2'd2;
            CODE_POW:              r = 2'd3;
            default:               r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/itp_stack.sv
// Operator stack storage: single write port, registered read port.
module itp_stack #(
    parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [2:0]    i_wr_code,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [2:0]    o_rd_code
);

    logic [2:0] r_mem [STACK_DEPTH];
    logic [2:0] r_rd_code;

    // Write the pushed code
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_code;
        end
    end

    // Register the top-of-stack read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_code <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_code = r_rd_code;

endmodule

### rtl/itp_class.sv
// Character classifier and precedence compare unit shared by all stack steps.
module itp_class (
    input  logic [7:0]      i_symbol,
    input  logic [2:0]      i_top,
    output itp_pkg::t_class o_class
);

    logic [2:0] code;

    // Decode the held character
    assign code = itp_pkg::classify(i_symbol);

    always_comb begin
        o_class.letter   = (i_symbol inside {[8'd97:8'd122], [8'd65:8'd90]});
        o_class.rparen   = (i_symbol == itp_pkg::CH_RPAR);
        o_class.code     = code;
        o_class.top_lpar = (i_top == itp_pkg::CODE_LPAR);
        // Pop while the top binds at least as tightly as the incoming operator
        o_class.top_pops = (itp_pkg::code_prec(i_top) >= itp_pkg::code_prec(code));
    end

endmodule

### rtl/infix_to_postfix_converter_top.sv
// Infix to postfix converter top level: sequencer, output register and stack.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one character per
// transfer, with end_of_expr marking the last one. Output channel
// (o_out_valid / i_out_ready / o_out_data) delivers postfix characters and,
// for every expression, one closing item with out_last set and the status.
// Each character is worked by a small sequencer that drives one compare unit
// and both stack ports. A letter, '(' or dropped character passes through
// the decode and tail states before the next transfer; a letter is emitted
// from the decode state. Every popped operator takes a stack read, then a
// compare and emit; pops end when the stack empties, at '(', or for an
// operator at a lower one. The final item adds the flush, a stack read and
// emit per remaining entry, then the empty check and the end marker (an
// error skips the flush and goes straight to the end marker).
// Ready is high only while the sequencer is idle and out of reset.
// Results sit in one output register; when the receiver stalls, the
// sequencer waits at the next emit and resumes once the register is taken.
// After an error, later characters of the expression are dropped; the end
// marker carries the error code. Synchronous reset empties the stack, clears
// the error and drops any pending result; stack contents need no clearing.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  itp_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output itp_pkg::t_out_item   o_out_data
);

`include "infix_to_postfix_converter_top_defines.svh"

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_LOOP_RD = 3'd2;
    localparam logic [2:0] S_LOOP_EV = 3'd3;
    localparam logic [2:0] S_TAIL    = 3'd4;
    localparam logic [2:0] S_END     = 3'd5;

    // Pop loop modes
    localparam logic [1:0] M_CLOSE = 2'd0;
    localparam logic [1:0] M_OP    = 2'd1;
    localparam logic [1:0] M_FLUSH = 2'd2;

    logic [2:0]          r_state, n_state;
    logic [1:0]          r_mode, n_mode;
    logic [CW-1:0]       r_count, n_count;
    logic [2:0]          r_err, n_err;
    itp_pkg::t_in_item   r_item;
    logic                r_out_valid;
    itp_pkg::t_out_item  r_out_data;

    logic                wr_en, rd_en, emit, out_free, full;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [CW-1:0]       count_m1;
    logic [2:0]          top_code;
    itp_pkg::t_out_item  emit_data;
    itp_pkg::t_class     cls;

    itp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_code (cls.code),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_code (top_code)
    );

    itp_class u_class (
        .i_symbol (r_item.symbol),
        .i_top    (top_code),
        .o_class  (cls)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign full     = (r_count == FULL_COUNT);
    assign count_m1 = r_count - CW'(1);

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_count   = r_count;
        n_err     = r_err;
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        rd_en     = 1'b0;
        rd_addr   = count_m1[AW-1:0];
        emit      = 1'b0;
        emit_data = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_err != itp_pkg::ST_OK) begin
                    n_state = S_TAIL;
                end else if (cls.letter) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_data = '{r_item.symbol, 1'b1, 1'b0, itp_pkg::ST_OK};
                        n_state   = S_TAIL;
                    end
                end else if (cls.rparen) begin
                    n_mode  = M_CLOSE;
                    n_state = S_LOOP_RD;
                end else if (cls.code == itp_pkg::CODE_LPAR) begin
                    if (full) begin
                        n_err = itp_pkg::ST_OVERFLOW;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    n_state = S_TAIL;
                end else if (cls.code != itp_pkg::CODE_NONE) begin
                    n_mode  = M_OP;
                    n_state = S_LOOP_RD;
                end else begin
                    n_err   = itp_pkg::ST_INVALID;
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (!r_item.end_of_expr) begin
                    n_state = S_IDLE;
                end else if (r_err == itp_pkg::ST_OK) begin
                    n_mode  = M_FLUSH;
                    n_state = S_LOOP_RD;
                end else begin
                    n_state = S_END;
                end
            end
            S_LOOP_RD: begin
                if (r_count == '0) begin
                    case (r_mode)
                        M_CLOSE: begin
                            n_err   = itp_pkg::ST_UNMATCHED;
                            n_state = S_TAIL;
                        end
                        M_OP: begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                            n_state = S_TAIL;
                        end
                        default: begin
                            n_state = S_END;
                        end
                    endcase
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_LOOP_EV;
                end
            end
            S_LOOP_EV: begin
                if (r_mode == M_CLOSE && cls.top_lpar) begin
                    // drop the matching open paren
                    n_count = count_m1;
                    n_state = S_TAIL;
                end else if (r_mode == M_OP && (cls.top_lpar || !cls.top_pops)) begin
                    if (full) begin
                        n_err = itp_pkg::ST_OVERFLOW;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    n_state = S_TAIL;
                end else if (r_mode == M_FLUSH && cls.top_lpar) begin
                    n_count = count_m1;
                    n_err   = itp_pkg::ST_UNCLOSED;
                    n_state = S_END;
                end else if (out_free) begin
                    emit      = 1'b1;
                    emit_data = '{itp_pkg::code_char(top_code), 1'b1, 1'b0, itp_pkg::ST_OK};
                    n_count   = count_m1;
                    n_state   = S_LOOP_RD;
                end
            end
            S_END: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_data = '{itp_pkg::CH_NUL, 1'b0, 1'b1, r_err};
                    n_count   = '0;
                    n_err     = itp_pkg::ST_OK;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_CLOSE;
            r_count <= '0;
            r_err   <= itp_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // Hold the accepted character
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

    // Load or drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= emit_data;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ITP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_COUNT, "stack count past depth")
    `ITP_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DECODE, "transfer not decoded")
    `ITP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, r_state == S_END && out_free, r_count == '0 && r_err == itp_pkg::ST_OK && o_out_valid && o_out_data.out_last, "end marker did not clear state")
    `ITP_ASSERT_NOW(a_flush_no_err, i_clk, i_rst_n, (r_state == S_LOOP_RD || r_state == S_LOOP_EV) && r_mode == M_FLUSH, r_err == itp_pkg::ST_OK, "flush after error")

endmodule
